// ===== rtl/core/midpoint_circle_rasterizer_macros.svh =====
// Assertion macros shared by the rasterizer checker.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define MCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define MCR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mcr_pkg.sv =====
// Shared constants and types of the midpoint circle rasterizer.
package mcr_pkg;

  localparam int DEF_COORD_BITS  = 10;
  localparam int DEF_RADIUS_BITS = 9;

  localparam int COLOR_BITS = 4;
  localparam logic [COLOR_BITS-1:0] PEN_RESET = 4'd5;

  // Command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Pixels per group and depth of the group queue.
  localparam int GROUP_PIXELS = 8;
  localparam int PIX_IDX_BITS = $clog2(GROUP_PIXELS);
  localparam int QUEUE_DEPTH  = 2;

  // Status of the group queue, seen by both the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } mcr_qstat_t;

endpackage

// ===== rtl/core/mcr_front.sv =====
// Front end: takes commands, runs the octant walk and hands pixel groups to the queue.
module mcr_front
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int RADIUS_BITS = DEF_RADIUS_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   command,
  input  logic [COORD_BITS-1:0]  center_x,
  input  logic [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  input  mcr_qstat_t             qstat,
  output logic                   push,
  output logic [COORD_BITS-1:0]  grp_cx,
  output logic [COORD_BITS-1:0]  grp_cy,
  output logic [RADIUS_BITS-1:0] grp_x,
  output logic [RADIUS_BITS-1:0] grp_y,
  output logic                   grp_fin
);

  localparam int DEC_BITS = RADIUS_BITS + 3;

  logic [RADIUS_BITS-1:0] col_offset;
  logic [RADIUS_BITS-1:0] row_offset;
  logic [DEC_BITS-1:0]    decision;
  logic [COORD_BITS-1:0]  latched_cx;
  logic [COORD_BITS-1:0]  latched_cy;
  logic                   active;

  logic                   accept;
  logic                   is_start;
  logic                   walking;
  logic [RADIUS_BITS-1:0] x_step;
  logic [RADIUS_BITS-1:0] y_step;
  logic [DEC_BITS-1:0]    x_ext;
  logic [DEC_BITS-1:0]    y_ext;
  logic [DEC_BITS-1:0]    d_step;
  logic [DEC_BITS-1:0]    d_start;
  logic                   fin_step;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign is_start = (command == CMD_START);
  assign walking  = active && (col_offset < row_offset);

  // One column of the walk; the decision value wraps at its own width.
  always_comb begin
    x_step = col_offset + RADIUS_BITS'(1);
    x_ext  = DEC_BITS'(col_offset) + DEC_BITS'(1);
    if (decision[DEC_BITS-1]) begin
      y_step = row_offset;
      y_ext  = DEC_BITS'(row_offset);
      d_step = decision + (x_ext << 1) + DEC_BITS'(1);
    end else begin
      y_step = row_offset - RADIUS_BITS'(1);
      y_ext  = DEC_BITS'(row_offset) - DEC_BITS'(1);
      d_step = decision + (x_ext << 1) - (y_ext << 1) + DEC_BITS'(1);
    end
    fin_step = (x_step >= y_step);
    d_start  = DEC_BITS'(1) - DEC_BITS'(radius);
  end

  assign push    = accept && (is_start || walking);
  assign grp_cx  = is_start ? center_x : latched_cx;
  assign grp_cy  = is_start ? center_y : latched_cy;
  assign grp_x   = is_start ? '0 : x_step;
  assign grp_y   = is_start ? radius : y_step;
  assign grp_fin = is_start ? (radius == '0) : fin_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_offset <= '0;
      row_offset <= '0;
      decision   <= '0;
      latched_cx <= '0;
      latched_cy <= '0;
      active     <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        latched_cx <= center_x;
        latched_cy <= center_y;
        col_offset <= '0;
        row_offset <= radius;
        decision   <= d_start;
        active     <= (radius != '0);
      end else if (walking) begin
        col_offset <= x_step;
        row_offset <= y_step;
        decision   <= d_step;
        active     <= !fin_step;
      end else begin
        active <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/mcr_queue.sv =====
// Short queue of pixel groups between the front and the back.
module mcr_queue
  import mcr_pkg::*;
#(
  parameter int WIDTH = 2 * DEF_COORD_BITS + 2 * DEF_RADIUS_BITS + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output mcr_qstat_t       qstat
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign qstat.full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== rtl/core/mcr_back.sv =====
// Back end: eight symmetric pixels per group, one per cycle unless stalled.
module mcr_back
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int RADIUS_BITS = DEF_RADIUS_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [COLOR_BITS-1:0]         cfg_data,
  input  mcr_qstat_t                    qstat,
  output logic                          pop,
  input  logic [COORD_BITS-1:0]         q_cx,
  input  logic [COORD_BITS-1:0]         q_cy,
  input  logic [RADIUS_BITS-1:0]        q_x,
  input  logic [RADIUS_BITS-1:0]        q_y,
  input  logic                          q_fin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS+1:0]  pixel_x,
  output logic signed [COORD_BITS+1:0]  pixel_y,
  output logic [COLOR_BITS-1:0]         color,
  output logic                          last,
  output logic                          finished
);

  localparam int PIX_BITS = COORD_BITS + 2;
  localparam int SUM_BITS = ((RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS) + 2;
  localparam logic [PIX_IDX_BITS-1:0] LAST_IDX = PIX_IDX_BITS'(GROUP_PIXELS - 1);

  logic                    busy;
  logic [PIX_IDX_BITS-1:0] idx;
  logic [COLOR_BITS-1:0]   pen_color;
  logic [COORD_BITS-1:0]   g_cx;
  logic [COORD_BITS-1:0]   g_cy;
  logic [RADIUS_BITS-1:0]  g_x;
  logic [RADIUS_BITS-1:0]  g_y;
  logic                    g_fin;

  logic                    advance;
  logic                    swap;
  logic                    neg_x;
  logic                    neg_y;
  logic [RADIUS_BITS-1:0]  off_a;
  logic [RADIUS_BITS-1:0]  off_b;
  logic [SUM_BITS-1:0]     sum_x;
  logic [SUM_BITS-1:0]     sum_y;

  assign advance = busy && (!out_valid || !out_stall);
  assign pop     = !qstat.empty && (!busy || (advance && idx == LAST_IDX));

  // Octant symmetry: which offset goes on which axis, and with what sign.
  always_comb begin
    swap  = idx inside {3'd1, 3'd2, 3'd5, 3'd6};
    neg_x = idx inside {[3'd2:3'd5]};
    neg_y = idx inside {[3'd4:3'd7]};
    off_a = swap ? g_y : g_x;
    off_b = swap ? g_x : g_y;
    sum_x = neg_x ? SUM_BITS'(g_cx) - SUM_BITS'(off_a) : SUM_BITS'(g_cx) + SUM_BITS'(off_a);
    sum_y = neg_y ? SUM_BITS'(g_cy) - SUM_BITS'(off_b) : SUM_BITS'(g_cy) + SUM_BITS'(off_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
      pen_color <= PEN_RESET;
    end else begin
      if (cfg_write) begin
        pen_color <= cfg_data;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // A new group takes over right as the closing pixel of the old one leaves.
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (advance) begin
        idx <= idx + PIX_IDX_BITS'(1);
        if (idx == LAST_IDX) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      g_cx  <= q_cx;
      g_cy  <= q_cy;
      g_x   <= q_x;
      g_y   <= q_y;
      g_fin <= q_fin;
    end
    if (advance) begin
      pixel_x  <= $signed(sum_x[PIX_BITS-1:0]);
      pixel_y  <= $signed(sum_y[PIX_BITS-1:0]);
      color    <= pen_color;
      last     <= (idx == LAST_IDX);
      finished <= (idx == LAST_IDX) && g_fin;
    end
  end

endmodule

// ===== rtl/core/midpoint_circle_rasterizer.sv =====
// Top level of the midpoint circle rasterizer: front end, group queue and pixel back end.
//
//   channel  direction  handshake            beat contents
//   in       sink       in_valid / in_stall  command, center_x, center_y, radius
//   out      source     out_valid / out_stall pixel_x, pixel_y, color, last, finished
//   cfg      sink       cfg_write            cfg_data (pen color)
//
// A start or a live step leaves a group of eight pixels, and the back end drives one
// pixel beat per cycle while out_stall is low, so a steady stream of commands is limited
// by the single pixel output port. A step that produces nothing pushes no group.
// Reset (rst, synchronous) empties the queue and the output and sets the pen color
// to its default of five.
// A stall on the output holds the current pixel; the front keeps taking commands
// until the two-entry group queue fills, then raises in_stall.
module midpoint_circle_rasterizer
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int RADIUS_BITS = DEF_RADIUS_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [COLOR_BITS-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [COORD_BITS-1:0]         center_x,
  input  logic [COORD_BITS-1:0]         center_y,
  input  logic [RADIUS_BITS-1:0]        radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS+1:0]  pixel_x,
  output logic signed [COORD_BITS+1:0]  pixel_y,
  output logic [COLOR_BITS-1:0]         color,
  output logic                          last,
  output logic                          finished
);

  // A queued group is the center, the two offsets and the end-of-walk flag.
  localparam int GRP_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

  mcr_qstat_t             qstat;
  logic                   push;
  logic                   pop;
  logic [COORD_BITS-1:0]  grp_cx;
  logic [COORD_BITS-1:0]  grp_cy;
  logic [RADIUS_BITS-1:0] grp_x;
  logic [RADIUS_BITS-1:0] grp_y;
  logic                   grp_fin;
  logic [GRP_BITS-1:0]    wr_data;
  logic [GRP_BITS-1:0]    rd_data;
  logic [COORD_BITS-1:0]  q_cx;
  logic [COORD_BITS-1:0]  q_cy;
  logic [RADIUS_BITS-1:0] q_x;
  logic [RADIUS_BITS-1:0] q_y;
  logic                   q_fin;

  mcr_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .qstat    (qstat),
    .push     (push),
    .grp_cx   (grp_cx),
    .grp_cy   (grp_cy),
    .grp_x    (grp_x),
    .grp_y    (grp_y),
    .grp_fin  (grp_fin)
  );

  assign wr_data = {grp_cx, grp_cy, grp_x, grp_y, grp_fin};
  assign {q_cx, q_cy, q_x, q_y, q_fin} = rd_data;

  mcr_queue #(
    .WIDTH (GRP_BITS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_data (rd_data),
    .qstat   (qstat)
  );

  mcr_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .pop       (pop),
    .q_cx      (q_cx),
    .q_cy      (q_cy),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_fin     (q_fin),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .color     (color),
    .last      (last),
    .finished  (finished)
  );

endmodule

// ===== rtl/core/mcr_checker.sv =====
// Port-level checker of the rasterizer and its bind to the top level.
`include "midpoint_circle_rasterizer_macros.svh"

module mcr_checker
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COORD_BITS+1:0]  pixel_x,
  input logic signed [COORD_BITS+1:0]  pixel_y,
  input logic [COLOR_BITS-1:0]         color,
  input logic                          last,
  input logic                          finished
);

  // Reset leaves no pixel pending and the input open.
  `MCR_ASSERT_RST(a_reset_clears, rst |=> !out_valid && !in_stall, "reset left beat pending")

  // A stalled pixel beat holds its contents.
  `MCR_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(color) && $stable(last) && $stable(finished), "stalled beat changed")

  // The eight pixels of a group leave without gaps.
  `MCR_ASSERT(a_group_gapless, out_valid && !out_stall && !last |=> out_valid, "gap inside pixel group")

  // The end of the walk is flagged only on the closing pixel of a group.
  `MCR_ASSERT(a_finished_on_last, out_valid && finished |-> last, "finished without last")

endmodule

bind midpoint_circle_rasterizer mcr_checker #(
  .COORD_BITS  (COORD_BITS)
) u_mcr_checker (.*);

// ===== dv/circle_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard class that traces expected circle pixels and checks pixel beats against them.
package circle_scoreboard_pkg;
  import mcr_pkg::*;

  localparam int CB = DEF_COORD_BITS;
  localparam int RB = DEF_RADIUS_BITS;
  localparam int PB = CB + 2;
  localparam int DB = RB + 3;

  typedef struct {
    logic signed [PB-1:0]  px;
    logic signed [PB-1:0]  py;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
    logic                  finished;
  } pixel_t;

  class circle_scoreboard;
    pixel_t pending_pixels[$];
    logic [COLOR_BITS-1:0] pen;
    logic [CB-1:0] org_x;
    logic [CB-1:0] org_y;
    logic [RB-1:0] col;
    logic [RB-1:0] row;
    logic signed [DB-1:0] decision;
    bit walking;
    int errors;

    function new();
      pen = PEN_RESET;
      org_x = '0;
      org_y = '0;
      col = '0;
      row = '0;
      decision = '0;
      walking = 1'b0;
      errors = 0;
    endfunction

    function void set_pen(logic [COLOR_BITS-1:0] value);
      pen = value;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("mismatch: %s", msg);
    endtask

    // Pushes the eight symmetric pixels of the current offsets.
    function void push_octants(bit fin);
      int dx[GROUP_PIXELS];
      int dy[GROUP_PIXELS];
      int ox, oy, cx, cy, vx, vy;
      pixel_t p;
      ox = int'(col);
      oy = int'(row);
      cx = int'(org_x);
      cy = int'(org_y);
      dx = '{ox, oy, -oy, -ox, -ox, -oy, oy, ox};
      dy = '{oy, ox, ox, oy, -oy, -ox, -ox, -oy};
      for (int k = 0; k < GROUP_PIXELS; k++) begin
        vx = cx + dx[k];
        vy = cy + dy[k];
        p.px = vx[PB-1:0];
        p.py = vy[PB-1:0];
        p.color = pen;
        p.last = (k == GROUP_PIXELS - 1);
        p.finished = p.last && fin;
        pending_pixels.push_back(p);
      end
    endfunction

    // Advances the traced walk for one accepted command beat.
    function void note_command(logic cmd, logic [CB-1:0] cx, logic [CB-1:0] cy,
                               logic [RB-1:0] r);
      int d, nx, ny;
      bit fin;
      if (cmd == CMD_START) begin
        org_x = cx;
        org_y = cy;
        col = '0;
        row = r;
        ny = int'(r);
        d = 1 - ny;
        decision = d[DB-1:0];
        fin = (col >= row);
        walking = !fin;
        push_octants(fin);
      end else if (!walking || col >= row) begin
        walking = 1'b0;
      end else begin
        d = int'(decision);
        nx = int'(col);
        nx = nx + 1;
        ny = int'(row);
        if (d < 0) begin
          d = d + 2 * nx + 1;
        end else begin
          ny = ny - 1;
          d = d + 2 * nx - 2 * ny + 1;
        end
        col = nx[RB-1:0];
        row = ny[RB-1:0];
        decision = d[DB-1:0];
        fin = (col >= row);
        if (fin) walking = 1'b0;
        push_octants(fin);
      end
    endfunction

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel (%0d,%0d)", got.px, got.py));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.px !== want.px || got.py !== want.py || got.color !== want.color ||
          got.last !== want.last || got.finished !== want.finished)
        report($sformatf("got (%0d,%0d) c%0d l%0b f%0b, want (%0d,%0d) c%0d l%0b f%0b",
                         got.px, got.py, got.color, got.last, got.finished,
                         want.px, want.py, want.color, want.last, want.finished));
    endtask

    function int pending();
      return pending_pixels.size();
    endfunction

    function int drop_leftover();
      int n;
      n = pending_pixels.size();
      pending_pixels.delete();
      return n;
    endfunction
  endclass

endpackage

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top that drives the midpoint circle rasterizer and checks every pixel beat.
module tb;
  import mcr_pkg::*;
  import circle_scoreboard_pkg::*;

  // Cycles to wait once nothing is expected, covering a trailing step that emits nothing.
  localparam int SETTLE_CYCLES = 24;
  // Upper bound on a single drain before leftover pixels are declared missing.
  localparam int DRAIN_LIMIT   = 20000;
  // Long receiver hold-off and the short release window that follows it.
  localparam int HOLD_CYCLES    = 300;
  localparam int RELEASE_CYCLES = 40;
  // Absolute run limit, far above the slowest legal run.
  localparam int TIMEOUT_NS     = 10_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [COLOR_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic command = 1'b0;
  logic [CB-1:0] center_x = '0;
  logic [CB-1:0] center_y = '0;
  logic [RB-1:0] radius = '0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic signed [PB-1:0] pixel_x;
  logic signed [PB-1:0] pixel_y;
  logic [COLOR_BITS-1:0] color;
  logic last;
  logic finished;

  circle_scoreboard sb = new();

  // Knobs of the current phase, read by the sender task and the receiver process.
  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit pressure = 1'b0;
  int hold_cnt = 0;
  int items_sent = 0;

  always #10 clk = ~clk;

  midpoint_circle_rasterizer #(
    .COORD_BITS  (CB),
    .RADIUS_BITS (RB)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .color     (color),
    .last      (last),
    .finished  (finished)
  );

  // Pixel receiver. Outputs are sampled at the edge before the block updates them, so a
  // beat counts when out_valid was high and our own stall was low going into this edge.
  // In the pressure phase the stall pattern is a long hold followed by a short release,
  // counted here, which backs the group queue up until the block stalls its input.
  always @(posedge clk) begin
    pixel_t got;
    if (!rst && out_valid && !out_stall) begin
      got.px = pixel_x;
      got.py = pixel_y;
      got.color = color;
      got.last = last;
      got.finished = finished;
      sb.check_pixel(got);
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (pressure) begin
      hold_cnt <= (hold_cnt == HOLD_CYCLES + RELEASE_CYCLES - 1) ? 0 : hold_cnt + 1;
      out_stall <= (hold_cnt < HOLD_CYCLES);
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one command beat and returns at the edge where it is taken. The payload is
  // only changed when a new beat is raised, so a stalled beat holds still.
  task automatic send_command(logic cmd, logic [CB-1:0] cx, logic [CB-1:0] cy,
                              logic [RB-1:0] r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    center_x <= cx;
    center_y <= cy;
    radius <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(cmd, cx, cy, r);
    items_sent++;
  endtask

  // A step beat carries random centre and radius bits that the block must ignore.
  task automatic send_step();
    send_command(CMD_STEP, CB'($urandom_range(1023)), CB'($urandom_range(1023)),
                 RB'($urandom_range(511)));
  endtask

  task automatic write_pen(logic [COLOR_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_pen(value);
  endtask

  // Stops offering beats, waits for every expected pixel, then lets a trailing step that
  // produced nothing work its way through before the caller touches the pen register.
  task automatic wait_drained();
    int guard;
    int missing;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending() != 0) begin
      missing = sb.drop_leftover();
      sb.report($sformatf("%0d expected pixels never arrived", missing));
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One well-formed circle: a start, then steps until the walk completes. Large circles
  // and a few small ones are cut short so the next start abandons the walk midway.
  // Sometimes one more step follows a finished walk, which must emit nothing.
  task automatic run_circle();
    int pick, cut, n;
    logic [RB-1:0] r;
    pick = $urandom_range(99);
    if (pick < 70) r = RB'($urandom_range(12));
    else if (pick < 92) r = RB'($urandom_range(60, 13));
    else r = RB'($urandom_range(511));
    send_command(CMD_START, CB'($urandom_range(1023)), CB'($urandom_range(1023)), r);
    cut = (r > 60 || $urandom_range(99) < 12) ? $urandom_range(25, 1) : -1;
    n = 0;
    while (sb.walking && n != cut) begin
      send_step();
      n++;
    end
    if (!sb.walking && $urandom_range(99) < 30) send_step();
  endtask

  task automatic run_phase(int idle, int stall, bit press, logic [COLOR_BITS-1:0] pen,
                           int quota);
    int target;
    wait_drained();
    write_pen(pen);
    sender_idle_pct = idle;
    stall_pct = stall;
    pressure = press;
    target = items_sent + quota;
    while (items_sent < target) begin
      if ($urandom_range(99) < 80) begin
        run_circle();
      end else begin
        // Noise: a bare command of either kind with random fields.
        send_command(1'($urandom_range(1)), CB'($urandom_range(1023)),
                     CB'($urandom_range(1023)), RB'($urandom_range(511)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the pen left at its reset value and no idling.
    // A step right after reset has no circle to advance.
    send_command(CMD_STEP, 10'd1023, 10'd1023, 9'd511);
    // Zero radius: eight pixels at the centre, finished at once, next step is dead.
    send_command(CMD_START, 10'd0, 10'd0, 9'd0);
    send_step();
    // Largest radius at a corner, a few steps, then a restart mid-walk.
    send_command(CMD_START, 10'd1023, 10'd0, 9'd511);
    repeat (3) send_step();
    send_command(CMD_START, 10'd1023, 10'd1023, 9'd1);
    send_step();
    send_step();
    // Pixels far off the low x edge and the high y edge.
    send_command(CMD_START, 10'd0, 10'd1023, 9'd511);
    send_step();
    // Short complete walks that hit both branches of the decision.
    send_command(CMD_START, 10'd512, 10'd512, 9'd5);
    while (sb.walking) send_step();
    send_command(CMD_START, 10'd1, 10'd1022, 9'd2);
    while (sb.walking) send_step();
    send_step();

    // Random phases, each setting a pen color, an idling rate and a receiver stall pattern.
    run_phase(0, 0, 1'b0, 4'd0, 70);
    run_phase(49, 0, 1'b0, 4'd15, 75);
    run_phase(0, 49, 1'b0, COLOR_BITS'($urandom_range(15)), 75);
    run_phase(13, 13, 1'b0, COLOR_BITS'($urandom_range(15)), 75);
    run_phase(0, 0, 1'b1, COLOR_BITS'($urandom_range(15)), 75);

    wait_drained();
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mcr_pkg.sv
rtl/core/mcr_front.sv
rtl/core/mcr_queue.sv
rtl/core/mcr_back.sv
rtl/core/midpoint_circle_rasterizer.sv
rtl/core/mcr_checker.sv
dv/circle_scoreboard_pkg.sv
dv/tb.sv
